### sv/asq_pkg.sv
package asq_pkg;

    // pipeline depth and field widths
    localparam int unsigned NUM_STG  = 11;
    localparam int unsigned NORM_STG = 2;
    localparam int unsigned SER_STG  = 6;
    localparam int unsigned FIX_STG  = 3;
    localparam int unsigned IN_W     = 32;
    localparam int unsigned OUT_W    = 16;
    localparam int unsigned CNT_W    = 5;

    // series coefficients, q16
    localparam logic [15:0] K_C4   = 16'd40960;
    localparam logic [15:0] K_C5   = 16'd45875;
    // 1/sqrt(2) in q16 and its rounding term
    localparam logic [15:0] K_RSQ2 = 16'd46341;
    localparam logic [31:0] K_RND  = 32'h0000_8000;

    typedef logic [NUM_STG-1:0] t_stg_en;

    // normalised operand and what is needed to undo the normalisation
    typedef struct packed {
        logic [IN_W-1:0]  n;
        logic [15:0]      c;
        logic [CNT_W-1:0] cnt;
        logic             trivial;
        logic             lsb;
    } t_norm;

    // series result travelling with its operand
    typedef struct packed {
        t_norm       nrm;
        logic [15:0] sum;
    } t_acc;

endpackage

### sv/asq_norm.sv
module asq_norm (
    input  logic                            i_clk,
    input  logic [asq_pkg::NORM_STG-1:0]    i_en,
    input  logic [asq_pkg::IN_W-1:0]        i_value,
    output asq_pkg::t_norm                  o_nrm
);

    logic [asq_pkg::CNT_W-1:0] lz;
    logic [asq_pkg::IN_W-1:0]  r_v;
    logic [asq_pkg::CNT_W-1:0] r_cnt;
    logic [asq_pkg::IN_W-1:0]  shifted;
    asq_pkg::t_norm            n_nrm;
    asq_pkg::t_norm            r_nrm;

    // leading zero count, highest set bit wins
    always_comb begin
        lz = '0;
        for (int i = 0; i < asq_pkg::IN_W; i++) begin
            if (i_value[i]) begin
                lz = asq_pkg::CNT_W'(asq_pkg::IN_W - 1 - i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_v   <= i_value;
            r_cnt <= lz;
        end
    end

    always_comb begin
        shifted       = r_v << r_cnt;
        n_nrm.n       = shifted;
        n_nrm.c       = ~shifted[31:16];
        n_nrm.cnt     = r_cnt;
        n_nrm.trivial = (r_v[31:1] == 31'd0);
        n_nrm.lsb     = r_v[0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_nrm <= n_nrm;
        end
    end

    assign o_nrm = r_nrm;

endmodule

### sv/asq_series.sv
module asq_series (
    input  logic                         i_clk,
    input  logic [asq_pkg::SER_STG-1:0]  i_en,
    input  asq_pkg::t_norm               i_nrm,
    output asq_pkg::t_acc                o_acc
);

    function automatic logic [15:0] mul_hi16(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        p = 32'(a) * 32'(b);
        return p[31:16];
    endfunction

    asq_pkg::t_norm r_nrm [asq_pkg::SER_STG];
    logic [15:0]    r_y   [asq_pkg::SER_STG];
    logic [15:0]    r_sum [asq_pkg::SER_STG];

    logic [15:0] y1, p3, y2, p4, y3, y4, y5;

    always_comb begin
        y1 = {1'b0, i_nrm.c[15:1]};
        p3 = mul_hi16(y1, i_nrm.c);
        y2 = {2'b00, p3[15:2]};
        p4 = mul_hi16(r_y[0], r_nrm[0].c);
        y3 = {1'b0, p4[15:1]};
        y4 = mul_hi16(r_y[2], asq_pkg::K_C4);
        y5 = mul_hi16(r_y[4], asq_pkg::K_C5);
    end

    // operand rides along
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_nrm[0] <= i_nrm;
        end
        for (int k = 1; k < asq_pkg::SER_STG; k++) begin
            if (i_en[k]) begin
                r_nrm[k] <= r_nrm[k-1];
            end
        end
    end

    // series terms and their running sum
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_y[0]   <= y2;
            r_sum[0] <= y1 + y2;
        end
        if (i_en[1]) begin
            r_y[1]   <= y3;
            r_sum[1] <= r_sum[0] + y3;
        end
        if (i_en[2]) begin
            r_y[2]   <= mul_hi16(r_y[1], r_nrm[1].c);
            r_sum[2] <= r_sum[1];
        end
        if (i_en[3]) begin
            r_y[3]   <= y4;
            r_sum[3] <= r_sum[2] + y4;
        end
        if (i_en[4]) begin
            r_y[4]   <= mul_hi16(r_y[3], r_nrm[3].c);
            r_sum[4] <= r_sum[3];
        end
        if (i_en[5]) begin
            r_y[5]   <= y5;
            r_sum[5] <= r_sum[4] + y5;
        end
    end

    assign o_acc.nrm = r_nrm[asq_pkg::SER_STG-1];
    assign o_acc.sum = r_sum[asq_pkg::SER_STG-1];

endmodule

### sv/asq_fixup.sv
module asq_fixup (
    input  logic                         i_clk,
    input  logic [asq_pkg::FIX_STG-1:0]  i_en,
    input  asq_pkg::t_acc                i_acc,
    output logic [asq_pkg::OUT_W-1:0]    o_root
);

    logic [15:0] yb, res, half;
    logic [31:0] sq, dif;
    logic [31:0] scaled;

    logic [15:0]               r9_y;
    logic [asq_pkg::CNT_W-1:0] r9_cnt;
    logic                      r9_trivial, r9_lsb;
    logic [15:0]               r10_y;
    logic                      r10_odd, r10_trivial, r10_lsb;
    logic [asq_pkg::OUT_W-1:0] r_root;

    // residual correction, arithmetic halving
    always_comb begin
        yb   = ~i_acc.sum;
        sq   = 32'(yb) * 32'(yb);
        dif  = i_acc.nrm.n - sq;
        res  = dif[31:16];
        half = {res[15], res[15:1]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r9_y       <= yb + half;
            r9_cnt     <= i_acc.nrm.cnt;
            r9_trivial <= i_acc.nrm.trivial;
            r9_lsb     <= i_acc.nrm.lsb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r10_y       <= r9_y >> r9_cnt[asq_pkg::CNT_W-1:1];
            r10_odd     <= r9_cnt[0];
            r10_trivial <= r9_trivial;
            r10_lsb     <= r9_lsb;
        end
    end

    assign scaled = asq_pkg::K_RND + 32'(r10_y) * 32'(asq_pkg::K_RSQ2);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            if (r10_trivial) begin
                r_root <= {15'd0, r10_lsb};
            end else if (r10_odd) begin
                r_root <= scaled[31:16];
            end else begin
                r_root <= r10_y;
            end
        end
    end

    assign o_root = r_root;

endmodule

### sv/approx_integer_sqrt_32.sv
// approximate 16-bit square root of a 32-bit unsigned word. one word is taken
// per clock while tready is high, and each result passes through every register
// stage in turn, held back only while the output side holds tready low.
// the pipeline is 11 register stages: two for the leading zero count and the
// normalising shift, six for the five-term series (one multiplier per stage),
// three for the residual correction, the denormalising shift and the odd-count
// scaling by 1/sqrt(2). operands 0 and 1 come back unchanged. the result
// carries the small, fixed error of the method; it is not a rounded root.
// a stalled output stops only the stages that are full, so empty stages keep
// filling and tready stays high while any bubble is left in the pipeline.
module approx_integer_sqrt_32 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [15:0] root
);

    localparam int unsigned LAST = asq_pkg::NUM_STG - 1;

    asq_pkg::t_stg_en r_vld;
    asq_pkg::t_stg_en en;
    asq_pkg::t_norm   nrm;
    asq_pkg::t_acc    acc;

    // stage k may load when it is empty or the stage after it loads too
    always_comb begin
        en[LAST] = !r_vld[LAST] || i_m_axis_tready;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    // valid bits move with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < asq_pkg::NUM_STG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // normalise: leading zeros, then shift
    asq_norm u_norm (
        .i_clk   (i_clk),
        .i_en    (en[1:0]),
        .i_value (i_s_axis_tdata),
        .o_nrm   (nrm)
    );

    // five-term series on the complement of the top half
    asq_series u_series (
        .i_clk (i_clk),
        .i_en  (en[7:2]),
        .i_nrm (nrm),
        .o_acc (acc)
    );

    // correction, denormalise and odd-count scaling
    asq_fixup u_fixup (
        .i_clk  (i_clk),
        .i_en   (en[10:8]),
        .i_acc  (acc),
        .o_root (o_m_axis_tdata)
    );

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_vld[LAST];

`ifndef ASSERT_OFF
    // an empty output stage lets the whole pipeline move
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[LAST] |-> o_s_axis_tready)
        else $error("input blocked with output stage empty");

    // an accepted word lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted word lost at entry");

    // a full stage that cannot hand on keeps its word
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && !en[1]) |=> r_vld[0])
        else $error("stalled word dropped in first stage");

    // a word one stage from the end reaches the output after a free cycle
    a_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAST-1] && en[LAST]) |=> o_m_axis_tvalid)
        else $error("word lost before output stage");
`endif

endmodule
